@@ rtl/dcm_pkg.sv @@
// types and constants shared by the depth color mapper
// no dependencies
package dcm_pkg;

    localparam int unsigned DIVIDEND_W = 32;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned ADDR_W     = 5;
    localparam logic [23:0] COLOR_BLUE = 24'h0000FF;

    typedef struct packed {
        logic        mode;
        logic [15:0] disparity;
        logic [11:0] table_address;
        logic [23:0] table_color;
        logic        last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } t_out_word;

    typedef enum logic [2:0] {
        REG_DISPLAY_MODE   = 3'd0,
        REG_INFINITY       = 3'd1,
        REG_NUMERATOR      = 3'd2,
        REG_MIN_INDEX      = 3'd3,
        REG_MAX_INDEX      = 3'd4,
        REG_MAX_DISPARITY  = 3'd5,
        REG_SCALE          = 3'd6,
        REG_TABLE_ENTRIES  = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        MODE_DIST_BLUE = 2'd0,
        MODE_DIST_CLIP = 2'd1,
        MODE_DISPARITY = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_display_mode;

    typedef enum logic [1:0] {
        SEL_BLACK = 2'd0,
        SEL_BLUE  = 2'd1,
        SEL_TABLE = 2'd2
    } t_color_sel;

    // item context carried alongside the divider
    typedef struct packed {
        logic        wr;
        logic        gate;
        logic        last;
        logic [11:0] addr;
        logic [23:0] color;
        logic [15:0] dv;
        logic [25:0] prod;
    } t_ctx;

endpackage

@@ rtl/depth_color_mapper_core.sv @@
// depth color mapper top level: pipelined divider, color table memory, APB registers
// depends on dcm_pkg
//
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_ready   dcm_pkg::t_in_word
//  out       output     o_out_valid / i_out_ready dcm_pkg::t_out_word
//  config    input      APB psel/penable/pwrite   32-bit registers at 4*i
//
// one word accepted per clock unless the output stalls; a pixel passes the input register,
// the divider stages (32-bit quotient, 4 quotient bits per stage) and the output register
// table writes ride the same pipeline and update the table in order with pixel reads
// reset is synchronous active low; the color table has no reset and is undefined until written
// a stalled output freezes the whole pipeline; input ready is output free or taken
module depth_color_mapper_core #(
    parameter int unsigned TABLE_DEPTH             = 4096,
    parameter int unsigned DISPARITY_FRACTION_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dcm_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dcm_pkg::t_out_word   o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [dcm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned AW             = $clog2(TABLE_DEPTH);
    localparam int unsigned STEPS          = 4;
    localparam int unsigned NUM_DIV_STAGES = dcm_pkg::DIVIDEND_W / STEPS;
    localparam logic [31:0] DEPTH32        = 32'(TABLE_DEPTH);

    // configuration registers
    logic [1:0]  r_display_mode;
    logic [15:0] r_infinity;
    logic [31:0] r_numerator;
    logic [11:0] r_min_index;
    logic [11:0] r_max_index;
    logic [15:0] r_max_disparity;
    logic [9:0]  r_scale;
    logic [12:0] r_table_entries;

    logic cfg_wr;
    dcm_pkg::t_reg cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = dcm_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode  <= 2'd0;
            r_infinity      <= 16'd0;
            r_numerator     <= 32'd0;
            r_min_index     <= 12'd0;
            r_max_index     <= 12'd4095;
            r_max_disparity <= 16'd0;
            r_scale         <= 10'd4;
            r_table_entries <= 13'd0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                dcm_pkg::REG_DISPLAY_MODE:  r_display_mode  <= pwdata[1:0];
                dcm_pkg::REG_INFINITY:      r_infinity      <= pwdata[15:0];
                dcm_pkg::REG_NUMERATOR:     r_numerator     <= pwdata;
                dcm_pkg::REG_MIN_INDEX:     r_min_index     <= pwdata[11:0];
                dcm_pkg::REG_MAX_INDEX:     r_max_index     <= pwdata[11:0];
                dcm_pkg::REG_MAX_DISPARITY: r_max_disparity <= pwdata[15:0];
                dcm_pkg::REG_SCALE:         r_scale         <= pwdata[9:0];
                dcm_pkg::REG_TABLE_ENTRIES: r_table_entries <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            dcm_pkg::REG_DISPLAY_MODE:  prdata = {30'd0, r_display_mode};
            dcm_pkg::REG_INFINITY:      prdata = {16'd0, r_infinity};
            dcm_pkg::REG_NUMERATOR:     prdata = r_numerator;
            dcm_pkg::REG_MIN_INDEX:     prdata = {20'd0, r_min_index};
            dcm_pkg::REG_MAX_INDEX:     prdata = {20'd0, r_max_index};
            dcm_pkg::REG_MAX_DISPARITY: prdata = {16'd0, r_max_disparity};
            dcm_pkg::REG_SCALE:         prdata = {22'd0, r_scale};
            dcm_pkg::REG_TABLE_ENTRIES: prdata = {19'd0, r_table_entries};
            default:                    prdata = 32'd0;
        endcase
    end

    // whole pipeline advances when the output register is free or being taken
    logic r_ov;
    logic en;
    assign en         = !r_ov || i_out_ready;
    assign o_in_ready = en;

    // stage 0: register word, divisor and disparity-mode product
    logic                r_v   [0:NUM_DIV_STAGES];
    dcm_pkg::t_ctx       r_ctx [0:NUM_DIV_STAGES];
    logic [31:0]         r_q   [0:NUM_DIV_STAGES];
    logic [15:0]         r_rem [0:NUM_DIV_STAGES];

    logic        in_acc;
    logic [17:0] dm_diff;
    logic [15:0] dm_clamp;
    dcm_pkg::t_ctx ctx0;

    assign in_acc = i_in_valid && en;

    always_comb begin
        dm_diff  = {2'b00, r_max_disparity} - {2'b00, i_in_word.disparity}
                   - {2'b00, r_infinity};
        dm_clamp = dm_diff[17] ? 16'd0 : dm_diff[15:0];
        ctx0.wr    = i_in_word.mode;
        ctx0.gate  = i_in_word.disparity > r_infinity;
        ctx0.last  = i_in_word.last_pixel;
        ctx0.addr  = i_in_word.table_address;
        ctx0.color = i_in_word.table_color;
        ctx0.dv    = i_in_word.disparity - r_infinity;
        ctx0.prod  = 26'(dm_clamp * r_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0] <= ctx0;
            r_q[0]   <= r_numerator;
            r_rem[0] <= 16'd0;
        end
    end

    // restoring divider, STEPS quotient bits per stage
    for (genvar s = 1; s <= NUM_DIV_STAGES; s++) begin : g_div
        logic [15:0] rem_n;
        logic [31:0] q_n;
        logic [16:0] trial;

        always_comb begin
            rem_n = r_rem[s-1];
            q_n   = r_q[s-1];
            trial = 17'd0;
            for (int k = 0; k < STEPS; k++) begin
                trial = {rem_n, q_n[31]};
                if (trial >= {1'b0, r_ctx[s-1].dv}) begin
                    trial = trial - {1'b0, r_ctx[s-1].dv};
                    q_n   = {q_n[30:0], 1'b1};
                end else begin
                    q_n   = {q_n[30:0], 1'b0};
                end
                rem_n = trial[15:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctx[s] <= r_ctx[s-1];
                r_q[s]   <= q_n;
                r_rem[s] <= rem_n;
            end
        end
    end

    // lookup stage: index select, bounds, table access
    dcm_pkg::t_ctx cl;
    logic [31:0] idx;
    logic [31:0] n_valid;
    logic        hit;
    logic        in_bounds;
    logic        tbl_we;
    dcm_pkg::t_color_sel sel;
    dcm_pkg::t_display_mode dmode;

    assign cl    = r_ctx[NUM_DIV_STAGES];
    assign dmode = dcm_pkg::t_display_mode'(r_display_mode);

    always_comb begin
        n_valid   = ({19'd0, r_table_entries} > DEPTH32) ? DEPTH32
                                                         : {19'd0, r_table_entries};
        if (dmode == dcm_pkg::MODE_DIST_BLUE || dmode == dcm_pkg::MODE_DIST_CLIP) begin
            idx = r_q[NUM_DIV_STAGES];
        end else begin
            idx = {6'd0, cl.prod} >> DISPARITY_FRACTION_BITS;
        end
        hit       = idx < n_valid;
        in_bounds = (idx >= {20'd0, r_min_index}) && (idx <= {20'd0, r_max_index});
        sel = dcm_pkg::SEL_BLACK;
        if (cl.gate) begin
            case (dmode)
                dcm_pkg::MODE_DIST_BLUE: sel = hit ? dcm_pkg::SEL_TABLE : dcm_pkg::SEL_BLUE;
                dcm_pkg::MODE_DIST_CLIP:
                    sel = (hit && in_bounds) ? dcm_pkg::SEL_TABLE : dcm_pkg::SEL_BLACK;
                default: sel = hit ? dcm_pkg::SEL_TABLE : dcm_pkg::SEL_BLACK;
            endcase
        end
        tbl_we = r_v[NUM_DIV_STAGES] && cl.wr && ({20'd0, cl.addr} < DEPTH32);
    end

    // color table memory, at most one write and one read per cycle while the pipeline advances
    logic [23:0] mem [0:TABLE_DEPTH-1];
    logic [23:0] r_rd;
    logic [AW-1:0] wr_addr;

    assign wr_addr = AW'({20'd0, cl.addr});

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (tbl_we) begin
                mem[wr_addr] <= cl.color;
            end
            r_rd <= mem[idx[AW-1:0]];
        end
    end

    // output register
    dcm_pkg::t_color_sel r_sel;
    logic                r_last;
    logic [23:0]         color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[NUM_DIV_STAGES] && !cl.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel  <= sel;
            r_last <= cl.last;
        end
    end

    always_comb begin
        case (r_sel)
            dcm_pkg::SEL_TABLE: color = r_rd;
            dcm_pkg::SEL_BLUE:  color = dcm_pkg::COLOR_BLUE;
            default:            color = 24'd0;
        endcase
        o_out_word.blue      = color[7:0];
        o_out_word.green     = color[15:8];
        o_out_word.red       = color[23:16];
        o_out_word.frame_end = r_last;
    end

    assign o_out_valid = r_ov;

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && r_ctx[0].gate |-> r_ctx[0].dv != 16'd0)
        else $error("zero divisor on gated pixel");
    a_table_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NUM_DIV_STAGES] && !cl.wr && sel == dcm_pkg::SEL_TABLE |-> idx < DEPTH32)
        else $error("table read beyond depth");
`endif

endmodule

@@ bench/testbench.sv @@
// self-checking bench for depth_color_mapper_core: random and directed pixel/table words
// depends on dcm_pkg and the depth_color_mapper_core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 4096;
    localparam int unsigned FRAC = 8;
    localparam int unsigned PIPE_LAT = 9;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    dcm_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    dcm_pkg::t_out_word o_out_word;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dcm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    depth_color_mapper_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers and table
    dcm_pkg::t_display_mode sh_mode;
    logic [15:0] sh_inf;
    logic [31:0] sh_num;
    logic [11:0] sh_min;
    logic [11:0] sh_max;
    logic [15:0] sh_maxd;
    logic [9:0] sh_scale;
    logic [12:0] sh_entries;
    logic [23:0] color_shadow [DEPTH];

    dcm_pkg::t_in_word pending_words[$];
    dcm_pkg::t_out_word expected_colors[$];
    int unsigned mismatch_cnt = 0;
    int unsigned pixels_checked = 0;
    int unsigned watchdog = 0;
    bit hold_sender = 1'b0;
    bit stim_done = 1'b0;

    // lookup with table size bound; hit says whether the index is a valid entry
    function automatic logic [23:0] table_color(input logic [31:0] idx, output bit hit);
        logic [12:0] n;
        n = (sh_entries > DEPTH) ? 13'(DEPTH) : sh_entries;
        hit = (idx < n);
        return hit ? color_shadow[idx[11:0]] : 24'h0;
    endfunction

    // disparity mode index, floored at zero before scaling
    function automatic logic [63:0] disparity_index(input logic [15:0] disp);
        logic signed [18:0] d;
        d = $signed({3'b0, sh_maxd}) - $signed({3'b0, disp}) - $signed({3'b0, sh_inf});
        if (d < 0) d = 0;
        return (64'(d) * 64'(sh_scale)) >> FRAC;
    endfunction

    function automatic logic [31:0] distance_index(input logic [15:0] disp);
        return sh_num / 32'(disp - sh_inf);
    endfunction

    // index the pixel would read, or -1 if it reads no entry
    function automatic longint read_index(input logic [15:0] disp);
        logic [31:0] q;
        logic [63:0] k;
        bit hit;
        logic [23:0] c;
        if (disp <= sh_inf) return -1;
        if (sh_mode == dcm_pkg::MODE_DIST_BLUE || sh_mode == dcm_pkg::MODE_DIST_CLIP) begin
            q = distance_index(disp);
            if (sh_mode == dcm_pkg::MODE_DIST_CLIP && (q < sh_min || q > sh_max)) return -1;
            c = table_color(q, hit);
            return hit ? longint'(q) : -1;
        end
        k = disparity_index(disp);
        if (k >= DEPTH) return -1;
        c = table_color(k[31:0], hit);
        return hit ? longint'(k) : -1;
    endfunction

    // predicted color for one pixel word
    function automatic dcm_pkg::t_out_word color_of_pixel(input dcm_pkg::t_in_word w);
        dcm_pkg::t_out_word r;
        logic [23:0] c;
        logic [31:0] q;
        logic [63:0] k;
        bit hit;
        c = 24'h0;
        if (w.disparity > sh_inf) begin
            if (sh_mode == dcm_pkg::MODE_DIST_BLUE || sh_mode == dcm_pkg::MODE_DIST_CLIP) begin
                q = distance_index(w.disparity);
                if (sh_mode == dcm_pkg::MODE_DIST_BLUE) begin
                    c = table_color(q, hit);
                    if (!hit) c = dcm_pkg::COLOR_BLUE;
                end else if (q >= sh_min && q <= sh_max) begin
                    c = table_color(q, hit);
                end
            end else begin
                k = disparity_index(w.disparity);
                if (k < DEPTH) c = table_color(k[31:0], hit);
            end
        end
        r.blue = c[7:0];
        r.green = c[15:8];
        r.red = c[23:16];
        r.frame_end = w.last_pixel;
        return r;
    endfunction

    // accepted flag latched at the rising edge for the driver
    logic accepted_in = 1'b0;
    always @(posedge i_clk) accepted_in <= i_in_valid && o_in_ready;

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_in_valid && !accepted_in) begin
            // hold the word until taken
        end else if (hold_sender || pending_words.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_in_word <= pending_words.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern, with calm stretches
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if ((stall_phase / 200) % 3 == 0) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 9) > 3);
    end

    // monitor: predict on accepted words, check on delivered colors
    always @(posedge i_clk) begin
        dcm_pkg::t_out_word e;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (i_in_word.mode) begin
                    // table write, no color
                    color_shadow[i_in_word.table_address] <= i_in_word.table_color;
                end else begin
                    expected_colors.push_back(color_of_pixel(i_in_word));
                end
            end
            if (o_out_valid && i_out_ready) begin
                pixels_checked <= pixels_checked + 1;
                if (expected_colors.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) $display("unexpected color word %h", o_out_word);
                end else begin
                    e = expected_colors.pop_front();
                    if (e !== o_out_word) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("color mismatch exp b=%h g=%h r=%h f=%b got b=%h g=%h r=%h f=%b",
                                e.blue, e.green, e.red, e.frame_end, o_out_word.blue,
                                o_out_word.green, o_out_word.red, o_out_word.frame_end);
                    end
                end
            end
            // watchdog on cycles with no handshake
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) watchdog <= 0;
            else if (!stim_done || expected_colors.size() != 0 || i_in_valid)
                watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // apb write: setup then access, shadow updated alongside
    task automatic reg_write(input dcm_pkg::t_reg r, input logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= dcm_pkg::ADDR_W'({r, 2'b00});
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            dcm_pkg::REG_DISPLAY_MODE:  sh_mode = dcm_pkg::t_display_mode'(v[1:0]);
            dcm_pkg::REG_INFINITY:      sh_inf = v[15:0];
            dcm_pkg::REG_NUMERATOR:     sh_num = v;
            dcm_pkg::REG_MIN_INDEX:     sh_min = v[11:0];
            dcm_pkg::REG_MAX_INDEX:     sh_max = v[11:0];
            dcm_pkg::REG_MAX_DISPARITY: sh_maxd = v[15:0];
            dcm_pkg::REG_SCALE:         sh_scale = v[9:0];
            dcm_pkg::REG_TABLE_ENTRIES: sh_entries = v[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait for all colors, then let the pipeline drain write words
    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // which entries the queued words will have written
    bit plan_written [DEPTH];

    task automatic queue_write(input logic [11:0] a, input logic [23:0] c);
        dcm_pkg::t_in_word w;
        w = '0;
        w.mode = 1'b1;
        w.table_address = a;
        w.table_color = c;
        w.disparity = 16'($urandom);
        w.last_pixel = 1'($urandom);
        plan_written[a] = 1'b1;
        pending_words.push_back(w);
    endtask

    // queue a pixel unless it reads an entry not yet written; returns 1 if queued
    function automatic bit queue_pixel(input logic [15:0] disp, input bit last);
        dcm_pkg::t_in_word w;
        longint k;
        k = read_index(disp);
        if (k >= 0 && !plan_written[k]) return 1'b0;
        w = '0;
        w.disparity = disp;
        w.last_pixel = last;
        w.table_address = 12'($urandom);
        w.table_color = 24'($urandom);
        pending_words.push_back(w);
        return 1'b1;
    endfunction

    // random pixel biased toward interesting disparities
    function automatic logic [15:0] pick_disparity();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return sh_inf + 16'($urandom_range(0, 3));
            2: return 16'hFFFF - 16'($urandom_range(0, 3));
            3: return sh_inf + 16'($urandom_range(1, 2048));
            default: return 16'($urandom_range(0, 4096));
        endcase
    endfunction

    int pixel_total = 0;
    int write_total = 0;

    task automatic run_phase(input int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_write(12'($urandom), 24'($urandom));
                write_total++;
            end else if (queue_pixel(pick_disparity(), 1'($urandom_range(0, 15) == 0))) begin
                pixel_total++;
            end else begin
                queue_write(12'($urandom), 24'($urandom));
                write_total++;
            end
        end
    endtask

    initial begin
        int i;
        sh_mode = dcm_pkg::MODE_DIST_BLUE;
        sh_inf = 16'd0;
        sh_num = 32'd0;
        sh_min = 12'd0;
        sh_max = 12'd4095;
        sh_maxd = 16'd0;
        sh_scale = 10'd4;
        sh_entries = 13'd0;
        for (i = 0; i < DEPTH; i++) plan_written[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the low part of the table, corner entries too
        reg_write(dcm_pkg::REG_TABLE_ENTRIES, 32'd4096);
        reg_write(dcm_pkg::REG_NUMERATOR, 32'd65536);
        for (i = 0; i < 512; i++) queue_write(12'(i), 24'($urandom));
        queue_write(12'd0, 24'hFFFFFF);
        queue_write(12'd4095, 24'h000000);
        write_total += 512 + 2;
        if (queue_pixel(16'd0, 1'b0)) pixel_total++;
        if (queue_pixel(16'd1, 1'b1)) pixel_total++;
        if (queue_pixel(16'hFFFF, 1'b0)) pixel_total++;
        if (queue_pixel(16'd16, 1'b0)) pixel_total++;
        if (queue_pixel(16'd256, 1'b1)) pixel_total++;
        // wait until everything has come back, then hold the sender while registers change
        drain();
        hold_sender = 1'b1;
        reg_write(dcm_pkg::REG_INFINITY, 32'd100);
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_DIST_CLIP));
        reg_write(dcm_pkg::REG_MIN_INDEX, 32'd10);
        reg_write(dcm_pkg::REG_MAX_INDEX, 32'd20);
        hold_sender = 1'b0;
        for (i = 0; i < 8; i++) if (queue_pixel(16'd100 + 16'(i * 700), 1'b0)) pixel_total++;
        drain();

        // random phases across register settings, extremes included
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_DIST_BLUE));
        reg_write(dcm_pkg::REG_INFINITY, 32'd0);
        reg_write(dcm_pkg::REG_NUMERATOR, 32'hFFFFFFFF);
        reg_write(dcm_pkg::REG_TABLE_ENTRIES, 32'd3000);
        run_phase(150);
        drain();
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_DIST_CLIP));
        reg_write(dcm_pkg::REG_NUMERATOR, 32'd1 << 20);
        reg_write(dcm_pkg::REG_MIN_INDEX, 32'd4095);
        reg_write(dcm_pkg::REG_MAX_INDEX, 32'd0);
        reg_write(dcm_pkg::REG_INFINITY, 32'd65535);
        run_phase(60);
        drain();
        reg_write(dcm_pkg::REG_INFINITY, 32'd512);
        reg_write(dcm_pkg::REG_MIN_INDEX, 32'd50);
        reg_write(dcm_pkg::REG_MAX_INDEX, 32'd3000);
        run_phase(150);
        drain();
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_DISPARITY));
        reg_write(dcm_pkg::REG_INFINITY, 32'd0);
        reg_write(dcm_pkg::REG_MAX_DISPARITY, 32'd65535);
        reg_write(dcm_pkg::REG_SCALE, 32'd1023);
        reg_write(dcm_pkg::REG_TABLE_ENTRIES, 32'd8191);
        run_phase(150);
        drain();
        reg_write(dcm_pkg::REG_SCALE, 32'd1);
        reg_write(dcm_pkg::REG_MAX_DISPARITY, 32'd4000);
        reg_write(dcm_pkg::REG_INFINITY, 32'd300);
        run_phase(150);
        drain();
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_UNUSED));
        reg_write(dcm_pkg::REG_SCALE, 32'd0);
        reg_write(dcm_pkg::REG_TABLE_ENTRIES, 32'd0);
        run_phase(60);
        drain();
        reg_write(dcm_pkg::REG_SCALE, 32'd64);
        reg_write(dcm_pkg::REG_TABLE_ENTRIES, 32'd4096);
        reg_write(dcm_pkg::REG_DISPLAY_MODE, 32'(dcm_pkg::MODE_DIST_BLUE));
        reg_write(dcm_pkg::REG_NUMERATOR, 32'd300000);
        reg_write(dcm_pkg::REG_INFINITY, 32'd0);
        run_phase(220);
        stim_done = 1'b1;
        while (pending_words.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        $display("run covered %0d pixel words and %0d table writes over all display modes",
            pixel_total, write_total);
        $display("colors checked %0d, mismatches %0d", pixels_checked, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_colors.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/dcm_pkg.sv
rtl/depth_color_mapper_core.sv
bench/testbench.sv
